>>> rtl/lsba_pkg.sv
// ----------------------------------------------------------------------------
// lsba_pkg: shared types and constants
// Opcodes, widths, the controller-to-datapath command struct and the status struct.
// ----------------------------------------------------------------------------
package lsba_pkg;

  localparam int LIMB_BITS_DEF = 64;
  localparam int WORD_W        = 64;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef struct packed {
    logic load;   // capture input word, clear running word on first
    logic step;   // one iteration of the active operation
    logic fin;    // move result into the output register
  } cmd_t;

  typedef struct packed {
    logic done;   // active operation finished
  } sts_t;

endpackage

>>> rtl/lsba_if.sv
// ----------------------------------------------------------------------------
// lsba_in_if / lsba_out_if: valid/ready channels
// Input word and result word channels of the limb-serial ALU.
// ----------------------------------------------------------------------------
interface lsba_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [63:0] limb_a;
  logic [63:0] limb_b;
  logic        first;
  logic        last;
  modport source (output valid, opcode, limb_a, limb_b, first, last, input ready);
  modport sink   (input valid, opcode, limb_a, limb_b, first, last, output ready);
endinterface

interface lsba_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_limb;
  logic [63:0] final_word;
  logic        end_of_number;
  logic        divide_by_zero;
  modport source (output valid, result_limb, final_word, end_of_number, divide_by_zero,
                  input ready);
  modport sink   (input valid, result_limb, final_word, end_of_number, divide_by_zero,
                  output ready);
endinterface

>>> rtl/lsba_ctrl.sv
// ----------------------------------------------------------------------------
// lsba_ctrl: sequencer
// Accepts a word, runs the datapath iterations, hands the result over.
// ----------------------------------------------------------------------------
module lsba_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          res_free,
  output lsba_pkg::cmd_t cmd,
  input  lsba_pkg::sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        cmd.step = 1'b1;
        if (sts.done) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (res_free) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

>>> rtl/lsba_dp.sv
// ----------------------------------------------------------------------------
// lsba_dp: arithmetic datapath
// Add/sub in one step, multiply as 32x32 partial products over four steps,
// divide one quotient bit per step after iteratively reducing a remainder >= b.
// ----------------------------------------------------------------------------
module lsba_dp #(
  parameter int LIMB_BITS = lsba_pkg::LIMB_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [1:0]     opcode,
  input  logic [63:0]    limb_a,
  input  logic [63:0]    limb_b,
  input  logic           first,
  input  logic           last,
  input  lsba_pkg::cmd_t cmd,
  output lsba_pkg::sts_t sts,
  output logic [63:0]    res_limb,
  output logic [63:0]    res_final,
  output logic           res_last,
  output logic           res_dz
);

  localparam int LB  = LIMB_BITS;
  localparam int CW  = $clog2(LB + 1) + 1;
  localparam logic [63:0] MASK = (LB == 64) ? {64{1'b1}} : ((64'd1 << LB) - 64'd1);

  logic [1:0]  op_r;
  logic [63:0] a_r, b_r, run_r, q_r;
  logic [63:0] lres_r;      // result limb of the word in progress
  logic [64:0] rem_r;       // divide working remainder incl. shifted-out bit
  logic        last_r, dz_r;
  logic [CW-1:0] cnt_r;
  logic        red_r;       // divide: reducing stale remainder phase
  logic [127:0] acc_r;      // multiply accumulator
  logic [6:0]  rcnt_r;      // reduction bit counter
  logic [63:0] rq_r;        // reduction: dividend shifted
  logic [1:0]  mphase_r;

  logic [64:0] sum;
  logic [63:0] sum_w;
  logic        done;

  // Reduction of stale running word: 64-step restoring remainder,
  // dividend bits from rq_r, divisor b_r.
  logic [64:0] rr_sh;
  logic [64:0] rd_sh;
  logic [5:0]  bit_idx;
  logic [31:0] pa, pb;
  logic [63:0] pp;
  logic [127:0] pp_sh, mul_sum, mul_hi;
  logic [63:0] b_in;
  logic        red_ld;

  assign bit_idx = 6'(cnt_r - CW'(1));
  assign rr_sh = {rem_r[63:0], rq_r[63]};
  assign rd_sh = {rem_r[63:0], a_r[bit_idx]};
  assign pa    = mphase_r[0] ? a_r[63:32] : a_r[31:0];
  assign pb    = mphase_r[1] ? b_r[63:32] : b_r[31:0];
  assign pp    = {32'd0, pa} * {32'd0, pb};
  assign b_in  = limb_b & MASK;
  assign red_ld = !first && (run_r >= b_in);

  // partial product placed by its weight
  always_comb begin
    case (mphase_r)
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
  end
  assign mul_sum = acc_r + pp_sh;
  assign mul_hi  = mul_sum >> LB;

  always_comb begin
    sum   = {1'b0, a_r} + {1'b0, b_r} + {64'd0, run_r[0]};
    sum_w = sum[63:0];
  end

  always_comb begin
    done = 1'b0;
    case (op_r)
      lsba_pkg::OP_ADD, lsba_pkg::OP_SUB: done = 1'b1;
      lsba_pkg::OP_MUL: done = (mphase_r == 2'd3);
      lsba_pkg::OP_DIV: done = dz_r || (!red_r && cnt_r == '0);
      default: done = 1'b1;
    endcase
  end
  assign sts.done = done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 64'd0;
    end else if (cmd.load) begin
      op_r     <= opcode;
      a_r      <= limb_a & MASK;
      b_r      <= b_in;
      last_r   <= last;
      dz_r     <= (opcode == lsba_pkg::OP_DIV) && (b_in == 64'd0);
      mphase_r <= 2'd0;
      acc_r    <= {64'd0, (first ? 64'd0 : run_r) & MASK};
      // below the divisor the old running word is the remainder as it is
      rem_r    <= (first || red_ld) ? 65'd0 : {1'b0, run_r};
      rq_r     <= first ? 64'd0 : run_r;
      red_r    <= red_ld;
      rcnt_r   <= 7'd0;
      q_r      <= 64'd0;
      cnt_r    <= CW'(LB);
      if (first) run_r <= 64'd0;
    end else if (cmd.step) begin
      case (op_r)
        lsba_pkg::OP_ADD: begin
          lres_r <= sum_w & MASK;
          run_r  <= (LB == 64) ? {63'd0, sum[64]} : {63'd0, sum_w[LB % 64]};
        end
        lsba_pkg::OP_SUB: begin
          lres_r <= (a_r - b_r - {63'd0, run_r[0]}) & MASK;
          run_r  <= {63'd0, (a_r < b_r) || (a_r == b_r && run_r[0])};
        end
        lsba_pkg::OP_MUL: begin
          acc_r    <= mul_sum;
          mphase_r <= mphase_r + 2'd1;
          if (mphase_r == 2'd3) begin
            lres_r <= mul_sum[63:0] & MASK;
            run_r  <= mul_hi[63:0] & MASK;
          end
        end
        lsba_pkg::OP_DIV: begin
          if (dz_r) begin
            lres_r <= MASK;
            run_r  <= 64'd0;
          end else if (red_r) begin
            // remainder of old running word mod b, one bit a step
            rq_r <= {rq_r[62:0], 1'b0};
            if (rr_sh >= {1'b0, b_r}) rem_r <= rr_sh - {1'b0, b_r};
            else                      rem_r <= rr_sh;
            rcnt_r <= rcnt_r + 7'd1;
            if (rcnt_r == 7'd63) red_r <= 1'b0;
          end else if (cnt_r != '0) begin
            cnt_r <= cnt_r - CW'(1);
            q_r   <= {q_r[62:0], (rd_sh >= {1'b0, b_r})};
            if (rd_sh >= {1'b0, b_r}) rem_r <= rd_sh - {1'b0, b_r};
            else                      rem_r <= rd_sh;
          end else begin
            lres_r <= q_r & MASK;
            run_r  <= rem_r[63:0];
          end
        end
        default: ;
      endcase
    end
    if (cmd.fin) begin
      res_limb  <= lres_r;
      res_final <= last_r ? run_r : 64'd0;
      res_last  <= last_r;
      res_dz    <= dz_r;
    end
  end

endmodule

>>> rtl/limb_serial_bignum_alu.sv
// ----------------------------------------------------------------------------
// limb_serial_bignum_alu: limb-serial add/sub/mul/div-by-word
// Top level joining the sequencer, datapath and output register.
// ----------------------------------------------------------------------------
// Usage:
//   in  : one word per limb (opcode, limb_a, limb_b, first, last); first
//         clears the running carry/borrow/high word/remainder.
//   out : one result word per input word; on last, final_word carries the
//         running word, end_of_number is set.
// Throughput: one word at a time; a new word is accepted only after the
// result of the last one is handed over. Add/sub and a zero divisor need
// the fewest steps; multiply sums four 32x32 partial products; divide first
// reduces a stale remainder that is not below the divisor. The divide loop,
// one quotient bit a cycle, sets the rate.
// Reset clears the controller, output valid and the running word. A stalled
// receiver holds the output register; the block finishes the next word then
// waits until the register is free.
// ----------------------------------------------------------------------------
module limb_serial_bignum_alu #(
  parameter int LIMB_BITS = lsba_pkg::LIMB_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  lsba_in_if.sink    in_ch,
  lsba_out_if.source out_ch
);

  lsba_pkg::cmd_t cmd;
  lsba_pkg::sts_t sts;
  logic        out_valid_r;
  logic        res_free;
  logic [63:0] res_limb, res_final;
  logic        res_last, res_dz;

  // output slot frees on take
  assign res_free = !out_valid_r || out_ch.ready;

  lsba_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .res_free,
    .cmd, .sts
  );

  lsba_dp #(.LIMB_BITS(LIMB_BITS)) u_dp (
    .clk,
    .rst_n,
    .opcode (in_ch.opcode),
    .limb_a (in_ch.limb_a),
    .limb_b (in_ch.limb_b),
    .first  (in_ch.first),
    .last   (in_ch.last),
    .cmd, .sts,
    .res_limb, .res_final, .res_last, .res_dz
  );

  always_ff @(posedge clk) begin
    if (!rst_n)             out_valid_r <= 1'b0;
    else if (cmd.fin)       out_valid_r <= 1'b1;
    else if (out_ch.ready)  out_valid_r <= 1'b0;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.result_limb    = res_limb;
  assign out_ch.final_word     = res_final;
  assign out_ch.end_of_number  = res_last;
  assign out_ch.divide_by_zero = res_dz;

  // held result stays while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> out_valid_r && $stable(res_limb))
    else $error("result dropped while stalled");
  // no load and hand-over together
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load && cmd.fin))
    else $error("load and finish together");
  // final word is zero on any result that is not the last
  a_fw: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !res_last |-> res_final == 64'd0)
    else $error("final word set mid-number");

endmodule
